FILE: hdl/rhsl_pkg.sv
package rhsl_pkg;

  localparam int CH_W        = 8;   // one color component
  localparam int LSUM_W      = 9;   // max plus min
  localparam int FRAC_W      = 16;  // Q0.16 hue and saturation
  localparam int DIV_W       = 11;  // divisor and remainder, up to 6 * 255
  localparam int DIV_STEPS   = 2;   // quotient bits resolved in one divider stage
  localparam int DIV_STAGES  = FRAC_W / DIV_STEPS;

  // Pipeline depth from an accepted pixel to a visible result.
  localparam int FRONT_STAGES = 2;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES;

  localparam logic [LSUM_W-1:0] LSUM_FULL = LSUM_W'(510);
  localparam logic [LSUM_W-1:0] LSUM_HALF = LSUM_W'(255);

  typedef enum logic [2:0] {
    SECTOR_RED   = 3'b001,
    SECTOR_GREEN = 3'b010,
    SECTOR_BLUE  = 3'b100
  } sector_t;

  // Data that rides alongside the divider stages.
  typedef struct packed {
    logic [LSUM_W-1:0] lightness_sum;
    logic              achromatic;
    logic              sat_full;
  } side_t;

endpackage

FILE: hdl/rhsl_if.sv
interface rhsl_in_if;
  logic                     valid;
  logic                     ready;
  logic [rhsl_pkg::CH_W-1:0] red;
  logic [rhsl_pkg::CH_W-1:0] green;
  logic [rhsl_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsl_out_if;
  logic                        valid;
  logic                        ready;
  logic [rhsl_pkg::FRAC_W-1:0] hue;
  logic [rhsl_pkg::FRAC_W-1:0] saturation;
  logic [rhsl_pkg::LSUM_W-1:0] lightness_sum;
  logic                        achromatic;

  modport source (output valid, output hue, output saturation, output lightness_sum,
                  output achromatic, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness_sum,
                  input achromatic, output ready);
endinterface

FILE: hdl/rhsl_frac_div.sv
// Pipelined restoring divider for a proper fraction: quo = floor(2^16 * num / den)
// with num < den. Each stage resolves DIV_STEPS quotient bits.
module rhsl_frac_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rhsl_pkg::DIV_W-1:0]    num,
  input  logic [rhsl_pkg::DIV_W-1:0]    den,
  output logic [rhsl_pkg::FRAC_W-1:0]   quo
);
  import rhsl_pkg::*;

  logic [DIV_W-1:0]  rem_q [DIV_STAGES];
  logic [DIV_W-1:0]  den_q [DIV_STAGES];
  logic [FRAC_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0]  rem_in;
    logic [DIV_W-1:0]  den_in;
    logic [FRAC_W-1:0] quo_in;
    logic [DIV_W-1:0]  rem_next;
    logic [FRAC_W-1:0] quo_next;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [DIV_W:0] rem2;
      rem_next = rem_in;
      quo_next = quo_in;
      for (int s = 0; s < DIV_STEPS; s++) begin
        rem2 = {rem_next, 1'b0};
        if (rem2 >= {1'b0, den_in}) begin
          rem_next = DIV_W'(rem2 - {1'b0, den_in});
          quo_next = {quo_next[FRAC_W-2:0], 1'b1};
        end else begin
          rem_next = rem2[DIV_W-1:0];
          quo_next = {quo_next[FRAC_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_next;
        den_q[k] <= den_in;
        quo_q[k] <= quo_next;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

FILE: hdl/rgb_to_hsl_pixel_unit.sv
// RGB to HSL converter. One pixel is taken per clock while pixel.ready is high,
// and results leave in pixel order. Two front stages find max, min, hue sector
// and the divider operands, then two 8-stage restoring dividers (2 quotient bits
// per stage) form saturation and hue side by side. An output skid register holds
// a result the sink does not take; while it is full the pipeline stalls and
// pixel.ready is low. Lightness is given as the exact sum max + min (0..510).
module rgb_to_hsl_pixel_unit (
  input  logic              clk,
  input  logic              rst,
  rhsl_in_if.sink           pixel,
  rhsl_out_if.source        hsl
);
  import rhsl_pkg::*;

  logic en;
  logic skid_valid;

  assign en          = !skid_valid;
  assign pixel.ready = !skid_valid;

  // Stage A: extremes and sector.
  logic [CH_W-1:0]   hi_c, lo_c;
  sector_t           sector_c;
  logic              a_valid;
  logic [CH_W-1:0]   a_red, a_green, a_blue, a_d;
  logic [LSUM_W-1:0] a_sum;
  sector_t           a_sector;

  always_comb begin
    hi_c = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    hi_c = (hi_c > pixel.blue) ? hi_c : pixel.blue;
    lo_c = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    lo_c = (lo_c < pixel.blue) ? lo_c : pixel.blue;
    priority if (pixel.red == hi_c) begin
      sector_c = SECTOR_RED;
    end else if (pixel.green == hi_c) begin
      sector_c = SECTOR_GREEN;
    end else begin
      sector_c = SECTOR_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_red    <= pixel.red;
      a_green  <= pixel.green;
      a_blue   <= pixel.blue;
      a_d      <= hi_c - lo_c;
      a_sum    <= {1'b0, hi_c} + {1'b0, lo_c};
      a_sector <= sector_c;
    end
  end

  // Stage B: divider operands.
  logic [DIV_W-1:0] d_w, six_d, hue_num_c;
  logic [CH_W-1:0]  sat_den_c;
  logic             b_valid;
  logic [DIV_W-1:0] b_hue_num, b_hue_den, b_sat_num, b_sat_den;
  side_t            b_side;

  assign d_w   = DIV_W'(a_d);
  assign six_d = DIV_W'({d_w, 2'b00}) + DIV_W'({d_w, 1'b0});

  always_comb begin
    unique case (a_sector)
      SECTOR_RED: begin
        // A negative numerator is moved up by a full turn.
        if (a_green >= a_blue) begin
          hue_num_c = DIV_W'(a_green - a_blue);
        end else begin
          hue_num_c = six_d - DIV_W'(a_blue - a_green);
        end
      end
      SECTOR_GREEN: hue_num_c = DIV_W'({d_w, 1'b0}) + DIV_W'(a_blue) - DIV_W'(a_red);
      SECTOR_BLUE:  hue_num_c = DIV_W'({d_w, 2'b00}) + DIV_W'(a_red) - DIV_W'(a_green);
      default:      hue_num_c = '0;
    endcase
    if (a_sum <= LSUM_HALF) begin
      sat_den_c = a_sum[CH_W-1:0];
    end else begin
      sat_den_c = CH_W'(LSUM_FULL - a_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_hue_num            <= hue_num_c;
      b_hue_den            <= six_d;
      b_sat_num            <= d_w;
      b_sat_den            <= DIV_W'(sat_den_c);
      b_side.lightness_sum <= a_sum;
      b_side.achromatic    <= (a_d == '0);
      // The quotient is exactly 1.0 only when d equals the divisor.
      b_side.sat_full      <= (a_d == sat_den_c);
    end
  end

  // Divider stages.
  logic [FRAC_W-1:0] hue_q, sat_q;

  rhsl_frac_div u_hue_div (
    .clk (clk),
    .en  (en),
    .num (b_hue_num),
    .den (b_hue_den),
    .quo (hue_q)
  );

  rhsl_frac_div u_sat_div (
    .clk (clk),
    .en  (en),
    .num (b_sat_num),
    .den (b_sat_den),
    .quo (sat_q)
  );

  logic  div_valid [DIV_STAGES];
  side_t div_side  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_valid[k] <= 1'b0;
      end
    end else if (en) begin
      div_valid[0] <= b_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_valid[k] <= div_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_side[0] <= b_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_side[k] <= div_side[k-1];
      end
    end
  end

  // Final result of the last stage.
  side_t             last_side;
  logic              last_valid;
  logic [FRAC_W-1:0] last_hue, last_sat;

  assign last_side  = div_side[DIV_STAGES-1];
  assign last_valid = div_valid[DIV_STAGES-1];

  always_comb begin
    if (last_side.achromatic) begin
      last_hue = '0;
      last_sat = '0;
    end else begin
      last_hue = hue_q;
      last_sat = last_side.sat_full ? '1 : sat_q;
    end
  end

  // Skid register.
  logic [FRAC_W-1:0] skid_hue, skid_sat;
  side_t             skid_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      skid_valid <= !hsl.ready;
    end else begin
      skid_valid <= last_valid && !hsl.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_hue  <= last_hue;
      skid_sat  <= last_sat;
      skid_side <= last_side;
    end
  end

  assign hsl.valid         = skid_valid || last_valid;
  assign hsl.hue           = skid_valid ? skid_hue : last_hue;
  assign hsl.saturation    = skid_valid ? skid_sat : last_sat;
  assign hsl.lightness_sum = skid_valid ? skid_side.lightness_sum : last_side.lightness_sum;
  assign hsl.achromatic    = skid_valid ? skid_side.achromatic : last_side.achromatic;

endmodule

FILE: hdl/rhsl_checker.sv
module rhsl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rhsl_pkg::FRAC_W-1:0]   hue,
  input logic [rhsl_pkg::FRAC_W-1:0]   saturation,
  input logic [rhsl_pkg::LSUM_W-1:0]   lightness_sum,
  input logic                          achromatic
);
  import rhsl_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(lightness_sum) && $stable(achromatic))
    else $error("stalled result changed");

  // Requests are refused only after a result was held back.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready dropped without output stall");

  a_achromatic_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && achromatic |-> hue == '0 && saturation == '0)
    else $error("achromatic result with nonzero hue or saturation");

  a_lsum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness_sum <= LSUM_FULL)
    else $error("lightness sum out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind rgb_to_hsl_pixel_unit rhsl_checker u_rhsl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pixel.ready),
  .out_valid     (hsl.valid),
  .out_ready     (hsl.ready),
  .hue           (hsl.hue),
  .saturation    (hsl.saturation),
  .lightness_sum (hsl.lightness_sum),
  .achromatic    (hsl.achromatic)
);
